@@ hdl/crt_pkg.sv @@
// Package for the camera relative translate block.
// Item types, fixed-point constants and the CORDIC arctangent table; no dependencies.
package crt_pkg;

  localparam int TRIG_W = 32;   // Q.30 trig values inside the CORDIC
  localparam int ANG_W  = 32;   // reduced angle, Q.28 radians
  localparam int ENT_W  = 33;   // matrix entries, Q.30, room for negation
  localparam int TERM_W = 35;   // one rounded displacement term
  localparam int SUM_W  = 37;   // position plus three terms
  localparam int MAX_STEPS = 24;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
  localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [31:0] move_dx;
    logic signed [31:0] move_dy;
    logic signed [31:0] move_dz;
  } crt_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               saturated;
  } crt_out_t;

  // one CORDIC lane: vector plus residual angle and fold flag
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    logic                     neg;
  } crt_lane_t;

  // arctangent of 2^-i in Q.28
  function automatic logic signed [ANG_W-1:0] atan_q28(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/crt_cordic_stage.sv @@
// One registered CORDIC rotation-mode iteration.
// Depends on crt_pkg for the lane type and the arctangent table.
module crt_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             adv,
  input  crt_pkg::crt_lane_t lane_in,
  output crt_pkg::crt_lane_t lane_out
);
  import crt_pkg::*;

  crt_lane_t lane_r, lane_nxt;

  // rotate toward zero residual angle
  always_comb begin
    lane_nxt = lane_in;
    if (!lane_in.z[ANG_W-1]) begin
      lane_nxt.x = lane_in.x - (lane_in.y >>> STEP);
      lane_nxt.y = lane_in.y + (lane_in.x >>> STEP);
      lane_nxt.z = lane_in.z - atan_q28(STEP);
    end else begin
      lane_nxt.x = lane_in.x + (lane_in.y >>> STEP);
      lane_nxt.y = lane_in.y - (lane_in.x >>> STEP);
      lane_nxt.z = lane_in.z + atan_q28(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;
endmodule

@@ hdl/crt_sincos.sv @@
// Sine and cosine of a Q3.12 angle: a registered range reduction, then a chain
// of CORDIC_STEPS registered iterations, capped at MAX_STEPS. Depends on crt_pkg and crt_cordic_stage.
module crt_sincos #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [15:0] angle,
  output crt_pkg::crt_lane_t lane_out
);
  import crt_pkg::*;

  localparam int NS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

  crt_lane_t red_r, red_nxt;
  crt_lane_t chain [NS+1];

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    logic signed [32:0] z;
    z = {angle[15], angle, 16'h0000};
    red_nxt.neg = 1'b0;
    if (z > PI_Q28) begin
      z = z - TWO_PI_Q28;
    end
    if (z < -PI_Q28) begin
      z = z + TWO_PI_Q28;
    end
    if (z > HALF_PI_Q28) begin
      z = z - PI_Q28;
      red_nxt.neg = 1'b1;
    end else if (z < -HALF_PI_Q28) begin
      z = z + PI_Q28;
      red_nxt.neg = 1'b1;
    end
    red_nxt.z = z[ANG_W-1:0];
    red_nxt.x = CORDIC_GAIN;
    red_nxt.y = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r <= red_nxt;
    end
  end

  assign chain[0] = red_r;

  for (genvar g = 0; g < NS; g++) begin : g_step
    crt_cordic_stage #(.STEP(g)) u_stage (
      .clk     (clk),
      .adv     (adv),
      .lane_in (chain[g]),
      .lane_out(chain[g+1])
    );
  end

  assign lane_out = chain[NS];
endmodule

@@ hdl/crt_rotate.sv @@
// Rotation of the displacement into world axes and the saturating add:
// entries, terms, then sum, each registered. Depends on crt_pkg.
module crt_rotate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid_in,
  input  crt_pkg::crt_in_t   item_in,
  input  crt_pkg::crt_lane_t yaw_lane,
  input  crt_pkg::crt_lane_t pitch_lane,
  output logic               valid_out,
  output crt_pkg::crt_out_t  item_out
);
  import crt_pkg::*;

  typedef logic signed [ENT_W-1:0]  ent_t;
  typedef logic signed [TERM_W-1:0] term_t;

  // Q.30 product rounded half up
  function automatic ent_t ent_mul(input ent_t a, input ent_t b);
    logic signed [2*ENT_W-1:0] p;
    p = a * b + (2*ENT_W)'(64'sd536870912);
    p = p >>> 30;
    return p[ENT_W-1:0];
  endfunction

  function automatic term_t term_mul(input logic signed [31:0] d, input ent_t e);
    logic signed [32+ENT_W-1:0] p;
    p = d * e + (32+ENT_W)'(64'sd536870912);
    p = p >>> 30;
    return p[TERM_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v,
                                               output logic hit);
    hit = 1'b0;
    if (v > SUM_W'(64'sd2147483647)) begin
      hit = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -SUM_W'(64'sd2147483648)) begin
      hit = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // stage A: signed trig values and cross entries
  logic v1_r, v2_r, v3_r;
  crt_in_t it1_r, it2_r;
  ent_t cy_r, sy_r, cp_r, sp_r, sysp_r, sycp_r, cysp_r, cycp_r;
  ent_t cy_nxt, sy_nxt, cp_nxt, sp_nxt;

  always_comb begin
    cy_nxt = yaw_lane.neg   ? -ENT_W'(yaw_lane.x)   : ENT_W'(yaw_lane.x);
    sy_nxt = yaw_lane.neg   ? -ENT_W'(yaw_lane.y)   : ENT_W'(yaw_lane.y);
    cp_nxt = pitch_lane.neg ? -ENT_W'(pitch_lane.x) : ENT_W'(pitch_lane.x);
    sp_nxt = pitch_lane.neg ? -ENT_W'(pitch_lane.y) : ENT_W'(pitch_lane.y);
  end

  // stage B: eight displacement terms
  term_t tx1_r, tx2_r, tx3_r, ty2_r, ty3_r, tz1_r, tz2_r, tz3_r;

  // stage C: sums and clipping
  crt_out_t out_r, out_nxt;

  always_comb begin
    logic hx, hy, hz;
    out_nxt.new_x = sat32(SUM_W'(it2_r.pos_x) + SUM_W'(tx1_r) + SUM_W'(tx2_r)
                          + SUM_W'(tx3_r), hx);
    out_nxt.new_y = sat32(SUM_W'(it2_r.pos_y) + SUM_W'(ty2_r) + SUM_W'(ty3_r), hy);
    out_nxt.new_z = sat32(SUM_W'(it2_r.pos_z) + SUM_W'(tz1_r) + SUM_W'(tz2_r)
                          + SUM_W'(tz3_r), hz);
    out_nxt.saturated = hx | hy | hz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r  <= item_in;
      cy_r   <= cy_nxt;
      sy_r   <= sy_nxt;
      cp_r   <= cp_nxt;
      sp_r   <= sp_nxt;
      sysp_r <= ent_mul(sy_nxt, sp_nxt);
      sycp_r <= ent_mul(sy_nxt, cp_nxt);
      cysp_r <= ent_mul(cy_nxt, sp_nxt);
      cycp_r <= ent_mul(cy_nxt, cp_nxt);

      it2_r <= it1_r;
      tx1_r <= term_mul(it1_r.move_dx, cy_r);
      tx2_r <= term_mul(it1_r.move_dy, sysp_r);
      tx3_r <= term_mul(it1_r.move_dz, sycp_r);
      ty2_r <= term_mul(it1_r.move_dy, -cp_r);
      ty3_r <= term_mul(it1_r.move_dz, sp_r);
      tz1_r <= term_mul(it1_r.move_dx, sy_r);
      tz2_r <= term_mul(it1_r.move_dy, -cysp_r);
      tz3_r <= term_mul(it1_r.move_dz, -cycp_r);

      out_r <= out_nxt;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign valid_out = v3_r;
  assign item_out  = out_r;
endmodule

@@ hdl/camera_relative_translate.sv @@
// CORDIC_STEPS is capped at 24.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the angle reduction stage, the one-iteration-per-stage CORDIC chain
// and three multiply/sum stages.
// Reset (synchronous, active low) clears every valid bit; data registers are not reset.
module camera_relative_translate #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  crt_pkg::crt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output crt_pkg::crt_out_t out_data
);
  import crt_pkg::*;

  localparam int NS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int DLY = NS + 1;

  logic adv;
  crt_lane_t yaw_lane, pitch_lane;
  crt_in_t item_dly_r [DLY];
  logic [DLY-1:0] vld_r;

  // global advance: hold only when a finished item waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  crt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .adv(adv), .angle(in_data.yaw_angle), .lane_out(yaw_lane)
  );

  crt_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .adv(adv), .angle(in_data.pitch_angle), .lane_out(pitch_lane)
  );

  // item fields ride alongside the CORDIC chain
  always_ff @(posedge clk) begin
    if (adv) begin
      item_dly_r[0] <= in_data;
      for (int i = 1; i < DLY; i++) begin
        item_dly_r[i] <= item_dly_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DLY-2:0], in_valid};
    end
  end

  crt_rotate u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_in  (vld_r[DLY-1]),
    .item_in   (item_dly_r[DLY-1]),
    .yaw_lane  (yaw_lane),
    .pitch_lane(pitch_lane),
    .valid_out (out_valid),
    .item_out  (out_data)
  );
endmodule

@@ hdl/crt_checker.sv @@
// Port-level checks for camera_relative_translate, bound to the top level.
// Depends on crt_pkg for the item types.
module crt_port_assert (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input crt_pkg::crt_out_t out_data
);
  import crt_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input stalls only behind a waiting result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is never stalled while no result is offered
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");
endmodule

bind camera_relative_translate crt_port_assert u_crt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ tb/sv/crt_checker.sv @@
// Checker for camera_relative_translate: watches both channels, predicts each
// result from the accepted item and compares field by field. Depends on crt_pkg.
`timescale 1ns / 1ps
module crt_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  crt_pkg::crt_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  crt_pkg::crt_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                seen_sat
);
  import crt_pkg::*;

  localparam int STEPS = 16;

  crt_out_t pose_q[$];

  initial begin
    fail_count = 0;
    seen_sat = 0;
    pending = 0;
  end

  // arctangent table for the angle residual, Q.28
  function automatic longint atan_step(input int i);
    longint t[24];
    t = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
          4193963, 2097109, 1048571, 524287, 262144, 131072,
          65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    return t[i];
  endfunction

  // Q.30 product, rounded half up
  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  // rotation-mode CORDIC with range fold
  function automatic void trig(input longint ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = ang * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 843314857) z -= 1686629713;
    if (z < -843314857) z += 1686629713;
    if (z > 421657428) begin
      z -= 843314857;
      flip = 1;
    end else if (z < -421657428) begin
      z += 843314857;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] clip(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic crt_out_t predict_pose(input crt_in_t d);
    longint cy, sy, cp, sp, dx, dy, dz;
    crt_out_t r;
    logic sat;
    sat = 0;
    trig(longint'(d.yaw_angle), cy, sy);
    trig(longint'(d.pitch_angle), cp, sp);
    dx = d.move_dx;
    dy = d.move_dy;
    dz = d.move_dz;
    r.new_x = clip(longint'(d.pos_x) + q30_mul(dx, cy) + q30_mul(dy, q30_mul(sy, sp))
                   + q30_mul(dz, q30_mul(sy, cp)), sat);
    r.new_y = clip(longint'(d.pos_y) + q30_mul(dy, -cp) + q30_mul(dz, sp), sat);
    r.new_z = clip(longint'(d.pos_z) + q30_mul(dx, sy) + q30_mul(dy, -q30_mul(cy, sp))
                   + q30_mul(dz, -q30_mul(cy, cp)), sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $time);
    fail_count++;
  endtask

  // sample both channels at the edge
  always @(posedge clk) begin
    crt_out_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) pose_q.push_back(predict_pose(in_data));
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected item new_x", out_data.new_x, 32'h0);
        end else begin
          e = pose_q.pop_front();
          if (out_data.saturated) seen_sat++;
          if (out_data.new_x !== e.new_x) report_mismatch("new_x", out_data.new_x, e.new_x);
          if (out_data.new_y !== e.new_y) report_mismatch("new_y", out_data.new_y, e.new_y);
          if (out_data.new_z !== e.new_z) report_mismatch("new_z", out_data.new_z, e.new_z);
          if (out_data.saturated !== e.saturated)
            report_mismatch("saturated", out_data.saturated, e.saturated);
        end
      end
    end
    pending = pose_q.size();
  end
endmodule

@@ tb/sv/tb_top.sv @@
// Top of the camera_relative_translate testbench: clock, reset, stimulus and verdict.
// Depends on crt_pkg, the block and crt_checker.
`timescale 1ns / 1ps
module tb_top;
  import crt_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_stall;
  crt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1;
  crt_out_t out_data;
  int       fail_count, pending, seen_sat;
  int       send_idle_pct = 17, recv_idle_pct = 83;
  logic     hold_go = 0;
  logic     hold_on = 0;
  int       sent = 0;

  camera_relative_translate u_dut (.*);

  crt_checker u_chk (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial begin
    #50ms;
    $display("timeout with %0d items outstanding", pending);
    $display("status: fail");
    $finish;
  end

  // receiver: random stall, forced while the long hold-off runs
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // long hold-off, counted here once the stimulus asks for it
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1;
    repeat (200) @(posedge clk);
    hold_on <= 0;
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff - $urandom_range(0, 65536 * 4);
      1: return 32'sh80000000 + $urandom_range(0, 65536 * 4);
      2: return $signed($urandom_range(0, 65536 * 64)) - 32'sd2097152;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return $signed(16'($urandom_range(0, 12868))) - 16'sd6434;  // within +-pi/2 wide
      1: return $signed(16'($urandom_range(0, 25736))) - 16'sd12868; // within +-pi
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one item and hold it until accepted
  task automatic send_pose(input crt_in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(input int count);
    crt_in_t d;
    repeat (count) begin
      d.pos_x = rand_coord();
      d.pos_y = rand_coord();
      d.pos_z = rand_coord();
      d.yaw_angle = rand_angle();
      d.pitch_angle = rand_angle();
      d.move_dx = rand_coord();
      d.move_dy = rand_coord();
      d.move_dz = rand_coord();
      send_pose(d);
    end
  endtask

  initial begin
    crt_in_t d;
    logic signed [15:0] angs[10];
    angs = '{16'sd0, 16'sd6434, -16'sd6434, 16'sd6433, 16'sd12868, -16'sd12868,
             16'sd12869, 16'sd32767, -16'sd32768, 16'sd3217};
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fold boundaries and wrap of both angles, extreme moves
    foreach (angs[i]) begin
      d = '{32'sd0, 32'sd65536, -32'sd65536, angs[i], angs[9 - i],
            32'sd655360, -32'sd327680, 32'sd131072};
      send_pose(d);
    end
    d = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 16'sd0, 16'sd0,
          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
    send_pose(d);
    d = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 16'sd3217, -16'sd3217,
          32'sh80000000, 32'sh80000000, 32'sh7fffffff};
    send_pose(d);
    d = '{32'hffffffff, 32'h55555555, 32'haaaaaaaa, 16'shffff, 16'sh5555,
          32'haaaaaaaa, 32'h55555555, 32'hffffffff};
    send_pose(d);
    d = '{32'sd0, 32'sd0, 32'sd0, 16'sh7fff, 16'sh8000, 32'sd0, 32'sd0, 32'sd0};
    send_pose(d);

    send_random(450);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct = 83;
    recv_idle_pct = 17;
    hold_go = 1;
    send_idle_pct = 0;
    send_random(60);
    send_idle_pct = 83;
    send_random(390);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(450);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("sent %0d pose updates, %0d results clipped", sent, seen_sat);
    $display("covered angle folds and wrap, saturation both ways, stalls and backpressure");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

@@ camera_relative_translate.f @@
hdl/crt_pkg.sv
hdl/crt_cordic_stage.sv
hdl/crt_sincos.sv
hdl/crt_rotate.sv
hdl/camera_relative_translate.sv
hdl/crt_checker.sv
tb/sv/crt_checker.sv
tb/sv/tb_top.sv
